### design/tof_histogram_binner_defines.svh
// Assertion macros for the histogram binner.
`ifndef TOF_HISTOGRAM_BINNER_DEFINES_SVH
`define TOF_HISTOGRAM_BINNER_DEFINES_SVH

`ifndef ASSERT_OFF

`define TOF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tof_histogram_binner: check failed");

`define TOF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tof_histogram_binner: check failed");

`else

`define TOF_ASSERT_IMP(lbl, ante, cons)

`define TOF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### design/tof_hb_pkg.sv
package tof_hb_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CH_FIELD_W = 4;
  localparam int unsigned RB_W      = 12;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MAX_CH    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PULSE = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BINNED  = 3'd0,
    ST_CH_OFF  = 3'd1,
    ST_NO_PULSE = 3'd2,
    ST_NEGATIVE = 3'd3,
    ST_ZERO_SCALE = 3'd4,
    ST_RANGE   = 3'd5,
    ST_PULSE   = 3'd6,
    ST_READ    = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_MASK = 2'd0,
    REG_BIN_SCALE    = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_CHECK,
    FSM_MUL,
    FSM_BIN,
    FSM_UPD,
    FSM_POST
  } fsm_t;

endpackage

### design/tof_hb_in_if.sv
interface tof_hb_in_if
  import tof_hb_pkg::*;
#(
  parameter int STAMP_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [CH_FIELD_W-1:0] channel;
  logic [STAMP_BITS-1:0] stamp;
  logic [RB_W-1:0]       read_bin;

  modport source (output valid, command, channel, stamp, read_bin, input ready);
  modport sink   (input valid, command, channel, stamp, read_bin, output ready);
endinterface

### design/tof_hb_out_if.sv
interface tof_hb_out_if
  import tof_hb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RB_W-1:0]     bin_index;
  logic [COUNT_W-1:0]  bin_count;
  logic [COUNT_W-1:0]  total_events;

  modport source (output valid, status, bin_index, bin_count, total_events, input ready);
  modport sink   (input valid, status, bin_index, bin_count, total_events, output ready);
endinterface

### design/tof_histogram_binner.sv
// Time-of-flight histogram binner. Pulse beats store a reference stamp per channel; event
// beats take (stamp - pulse stamp) * bin_scale (unsigned Q8.24), truncate to a bin and
// increment that bin in a block RAM of NUM_BINS 32-bit counters (saturating), along with a
// saturating event total. Read beats return one bin's count. One beat is handled at a time:
// the sequencer steps an event through the subtract, the two 32x32 multipliers, the bin
// compare and the RAM read-modify-write, while pulses and reads skip the multipliers. The
// result register lets the next beat be accepted while a result is still waiting. After
// reset the RAM is cleared one bin per cycle, so no beat is accepted until every bin is
// cleared; configuration writes are taken throughout.
`include "tof_histogram_binner_defines.svh"

module tof_histogram_binner
  import tof_hb_pkg::*;
#(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_BINS     = 4096,
  parameter int STAMP_BITS   = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tof_hb_in_if.sink             in_ch,
  tof_hb_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CH_N  = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
  localparam int CH_W  = (CH_N > 1) ? $clog2(CH_N) : 1;
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int XW    = (BIN_W > RB_W) ? BIN_W : RB_W;
  localparam int SUM_W = BIN_W + 9;
  localparam longint unsigned A_LIM = longint'(NUM_BINS / 256) + 64'd1;

  fsm_t state_r, state_nxt;

  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [CH_FIELD_W-1:0] ch_r, ch_nxt;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [RB_W-1:0]       rb_r, rb_nxt;
  logic [63:0]           diff_r, diff_nxt;
  logic [63:0]           prod_hi_r, prod_hi_nxt;
  logic [63:0]           prod_lo_r, prod_lo_nxt;
  logic [BIN_W-1:0]      bin_r, bin_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [RB_W-1:0]       res_idx_r, res_idx_nxt;
  logic [COUNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic                  hist_wr_r, hist_wr_nxt;
  logic [BIN_W-1:0]      clr_addr_r, clr_addr_nxt;

  logic [STAMP_BITS-1:0] pulse_stamp_r [CH_N];
  logic [CH_N-1:0]       pulse_valid_r, pulse_valid_nxt;
  logic                  pulse_we;

  logic [MASK_W-1:0]     mask_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [COUNT_W-1:0]    event_total_r, event_total_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [RB_W-1:0]       out_idx_r, out_idx_nxt;
  logic [COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [COUNT_W-1:0]    hist_mem [NUM_BINS];
  logic [COUNT_W-1:0]    mem_rdata_r;
  logic                  mem_we, mem_re;
  logic [BIN_W-1:0]      mem_waddr, mem_raddr;
  logic [COUNT_W-1:0]    mem_wdata;

  logic [CH_W-1:0]       ch_idx;
  logic                  ch_on;
  logic [STAMP_BITS-1:0] pulse_q;
  logic                  out_free;
  logic [39:0]           lo_hi;
  logic [SUM_W-1:0]      bin_sum;
  logic [XW-1:0]         rb_x;
  logic [XW-1:0]         bin_x;
  logic                  in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign ch_idx  = ch_r[CH_W-1:0];
  assign ch_on   = (32'(ch_r) < 32'(CH_N)) && mask_r[ch_r];
  assign pulse_q = pulse_stamp_r[ch_idx];
  assign out_free = !out_valid_r || out_ch.ready;
  assign lo_hi   = prod_lo_r[63:24];
  assign bin_sum = SUM_W'({prod_hi_r[BIN_W-1:0], 8'b0}) + SUM_W'(lo_hi[BIN_W-1:0]);
  assign rb_x    = XW'(rb_r);
  assign bin_x   = XW'(bin_r);

  assign in_ch.ready         = (state_r == FSM_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.bin_index    = out_idx_r;
  assign out_ch.bin_count    = out_cnt_r;
  assign out_ch.total_events = event_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FSM_CLEAR;
      clr_addr_r    <= '0;
      pulse_valid_r <= '0;
      event_total_r <= '0;
      out_valid_r   <= 1'b0;
      hist_wr_r     <= 1'b0;
      mask_r        <= MASK_W'(1);
      scale_r       <= SCALE_W'(32'h0100_0000);
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      pulse_valid_r <= pulse_valid_nxt;
      event_total_r <= event_total_nxt;
      out_valid_r   <= out_valid_nxt;
      hist_wr_r     <= hist_wr_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_CHANNEL_MASK) begin
          mask_r <= cfg_wdata[MASK_W-1:0];
        end else if (cfg_idx == REG_BIN_SCALE) begin
          scale_r <= cfg_wdata[SCALE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ch_r         <= ch_nxt;
    stamp_r      <= stamp_nxt;
    rb_r         <= rb_nxt;
    diff_r       <= diff_nxt;
    prod_hi_r    <= prod_hi_nxt;
    prod_lo_r    <= prod_lo_nxt;
    bin_r        <= bin_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_cnt_r    <= res_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_cnt_r    <= out_cnt_nxt;
    if (pulse_we) begin
      pulse_stamp_r[ch_idx] <= stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= hist_mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    ch_nxt          = ch_r;
    stamp_nxt       = stamp_r;
    rb_nxt          = rb_r;
    diff_nxt        = diff_r;
    prod_hi_nxt     = prod_hi_r;
    prod_lo_nxt     = prod_lo_r;
    bin_nxt         = bin_r;
    res_status_nxt  = res_status_r;
    res_idx_nxt     = res_idx_r;
    res_cnt_nxt     = res_cnt_r;
    hist_wr_nxt     = hist_wr_r;
    clr_addr_nxt    = clr_addr_r;
    pulse_valid_nxt = pulse_valid_r;
    pulse_we        = 1'b0;
    event_total_nxt = event_total_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_idx_nxt     = out_idx_r;
    out_cnt_nxt     = out_cnt_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = bin_r;
    mem_raddr       = bin_r;
    mem_wdata       = res_cnt_r;

    unique case (state_r)
      FSM_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + BIN_W'(1);
        if (clr_addr_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.command;
          ch_nxt    = in_ch.channel;
          stamp_nxt = in_ch.stamp;
          rb_nxt    = in_ch.read_bin;
          state_nxt = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        res_idx_nxt = '0;
        res_cnt_nxt = '0;
        hist_wr_nxt = 1'b0;
        state_nxt   = FSM_POST;
        priority case (cmd_r)
          CMD_PULSE: begin
            if (!ch_on) begin
              res_status_nxt = ST_CH_OFF;
            end else begin
              pulse_we                = 1'b1;
              pulse_valid_nxt[ch_idx] = 1'b1;
              res_status_nxt          = ST_PULSE;
            end
          end
          CMD_EVENT: begin
            if (!ch_on) begin
              res_status_nxt = ST_CH_OFF;
            end else if (!pulse_valid_r[ch_idx]) begin
              res_status_nxt = ST_NO_PULSE;
            end else if (scale_r == '0) begin
              res_status_nxt = ST_ZERO_SCALE;
            end else if (stamp_r < pulse_q) begin
              res_status_nxt = ST_NEGATIVE;
            end else begin
              diff_nxt  = 64'(stamp_r - pulse_q);
              state_nxt = FSM_MUL;
            end
          end
          default: begin
            res_idx_nxt = rb_r;
            if (32'(rb_r) >= 32'(NUM_BINS)) begin
              res_status_nxt = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = rb_x[BIN_W-1:0];
              state_nxt = FSM_UPD;
            end
          end
        endcase
      end
      FSM_MUL: begin
        prod_hi_nxt = diff_r[63:32] * 64'(scale_r);
        prod_lo_nxt = 64'(diff_r[31:0]) * 64'(scale_r);
        state_nxt   = FSM_BIN;
      end
      FSM_BIN: begin
        if ((prod_hi_r > A_LIM) || (lo_hi >= 40'(NUM_BINS))
            || (bin_sum >= SUM_W'(NUM_BINS))) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = FSM_POST;
        end else begin
          bin_nxt   = bin_sum[BIN_W-1:0];
          mem_re    = 1'b1;
          mem_raddr = bin_sum[BIN_W-1:0];
          state_nxt = FSM_UPD;
        end
      end
      FSM_UPD: begin
        state_nxt = FSM_POST;
        if (cmd_r == CMD_EVENT) begin
          res_status_nxt = ST_BINNED;
          res_idx_nxt    = bin_x[RB_W-1:0];
          res_cnt_nxt    = (mem_rdata_r == COUNT_MAX) ? mem_rdata_r
                                                      : mem_rdata_r + COUNT_W'(1);
          hist_wr_nxt    = 1'b1;
        end else begin
          res_status_nxt = ST_READ;
          res_cnt_nxt    = mem_rdata_r;
        end
      end
      FSM_POST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_cnt_nxt    = res_cnt_r;
          state_nxt      = FSM_IDLE;
          if (hist_wr_r) begin
            mem_we      = 1'b1;
            hist_wr_nxt = 1'b0;
            if (event_total_r != COUNT_MAX) begin
              event_total_nxt = event_total_r + COUNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  `TOF_ASSERT_IMP(a_mem_wr_src, mem_we && (state_r != FSM_CLEAR), (state_r == FSM_POST) && out_free && hist_wr_r)
  `TOF_ASSERT_IMP(a_binned_nonzero, out_valid_r && (out_status_r == ST_BINNED), out_cnt_r != '0)
  `TOF_ASSERT_NXT(a_total_hold, !((state_r == FSM_POST) && out_free && hist_wr_r), $stable(event_total_r))
  `TOF_ASSERT_NXT(a_out_from_post, !out_valid_r && !((state_r == FSM_POST) && out_free), !out_valid_r)

endmodule

### dv/tb_tof_histogram_binner.sv
module tb_tof_histogram_binner;
  timeunit 1ns;
  timeprecision 1ps;
  import tof_hb_pkg::*;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_BINS     = 4096;
  localparam int STAMP_BITS   = 48;
  localparam int Q_FRAC       = 24;

  localparam logic [CMD_W-1:0]      CMD_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_3 = 2'd3;
  localparam logic [STAMP_BITS-1:0] STAMP_TOP   = '1;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [CH_FIELD_W-1:0] channel;
    logic [STAMP_BITS-1:0] stamp;
    logic [RB_W-1:0]       read_bin;
  } tof_in_t;

  typedef struct packed {
    status_t            status;
    logic [RB_W-1:0]    bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] total_events;
  } tof_out_t;

  typedef struct {
    bit                    is_reg;
    bit                    known;
    tof_in_t               beat;
    tof_out_t              want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tof_hb_in_if #(.STAMP_BITS(STAMP_BITS)) in_if ();
  tof_hb_out_if out_if ();

  tof_histogram_binner #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .NUM_BINS    (NUM_BINS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  logic [MASK_W-1:0]     mask_now     = 16'h0001;
  logic [SCALE_W-1:0]    scale_now    = 32'h0100_0000;
  logic [STAMP_BITS-1:0] pulse_at [MAX_CH] = '{default: '0};
  logic [MAX_CH-1:0]     pulse_seen   = '0;
  logic [COUNT_W-1:0]    bin_counts [NUM_BINS] = '{default: '0};
  logic [COUNT_W-1:0]    binned_total = '0;

  tof_out_t        expected_q [$];
  logic [RB_W-1:0] hot_slots [$];
  int              errors    = 0;
  bit              src_calm  = 1'b0;
  bit              sink_calm = 1'b0;

  function automatic tof_out_t tof_bin(input tof_in_t b);
    tof_out_t                                r;
    logic [STAMP_BITS-1:0]                   diff;
    logic [STAMP_BITS+SCALE_W-1:0]           prod;
    logic [STAMP_BITS+SCALE_W-Q_FRAC-1:0]    slot;
    bit                                      on;
    r.status    = ST_READ;
    r.bin_index = '0;
    r.bin_count = '0;
    on = (b.channel < NUM_CHANNELS) && (b.channel < MAX_CH) && mask_now[b.channel];
    case (b.command)
      CMD_PULSE: begin
        if (!on) begin
          r.status = ST_CH_OFF;
        end else begin
          pulse_at[b.channel]   = b.stamp;
          pulse_seen[b.channel] = 1'b1;
          r.status = ST_PULSE;
        end
      end
      CMD_EVENT: begin
        if (!on) begin
          r.status = ST_CH_OFF;
        end else if (!pulse_seen[b.channel]) begin
          r.status = ST_NO_PULSE;
        end else if (scale_now == '0) begin
          r.status = ST_ZERO_SCALE;
        end else if (b.stamp < pulse_at[b.channel]) begin
          r.status = ST_NEGATIVE;
        end else begin
          diff = b.stamp - pulse_at[b.channel];
          prod = diff * scale_now;
          slot = prod >> Q_FRAC;
          if (slot >= NUM_BINS) begin
            r.status = ST_RANGE;
          end else begin
            if (bin_counts[slot] != COUNT_MAX) bin_counts[slot] += 1'b1;
            if (binned_total != COUNT_MAX) binned_total += 1'b1;
            r.status    = ST_BINNED;
            r.bin_index = slot[RB_W-1:0];
            r.bin_count = bin_counts[slot];
          end
        end
      end
      default: begin
        r.bin_index = b.read_bin;
        if (b.read_bin >= NUM_BINS) begin
          r.status = ST_RANGE;
        end else begin
          r.status    = ST_READ;
          r.bin_count = bin_counts[b.read_bin];
        end
      end
    endcase
    r.total_events = binned_total;
    return r;
  endfunction

  function automatic logic [CH_FIELD_W-1:0] pick_channel();
    logic [CH_FIELD_W-1:0] c;
    c = CH_FIELD_W'($urandom);
    if (mask_now != '0) begin
      while (!mask_now[c]) c = CH_FIELD_W'($urandom);
    end
    return c;
  endfunction

  function automatic script_row_t beat_row(input logic [CMD_W-1:0] cmd,
                                           input logic [CH_FIELD_W-1:0] ch,
                                           input logic [STAMP_BITS-1:0] stamp,
                                           input logic [RB_W-1:0] rb);
    script_row_t r;
    r.is_reg = 1'b0;
    r.known  = 1'b0;
    r.beat   = '{command: cmd, channel: ch, stamp: stamp, read_bin: rb};
    r.want   = '{status: ST_BINNED, bin_index: '0, bin_count: '0, total_events: '0};
    r.idx    = REG_CHANNEL_MASK;
    r.data   = '0;
    return r;
  endfunction

  function automatic script_row_t known_row(input logic [CMD_W-1:0] cmd,
                                            input logic [CH_FIELD_W-1:0] ch,
                                            input logic [STAMP_BITS-1:0] stamp,
                                            input logic [RB_W-1:0] rb,
                                            input status_t st,
                                            input logic [RB_W-1:0] idx,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic [COUNT_W-1:0] tot);
    script_row_t r;
    r       = beat_row(cmd, ch, stamp, rb);
    r.known = 1'b1;
    r.want  = '{status: st, bin_index: idx, bin_count: cnt, total_events: tot};
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r        = beat_row(CMD_PULSE, '0, '0, '0);
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNEL_MASK: mask_now  = data[MASK_W-1:0];
      REG_BIN_SCALE:    scale_now = data[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_beat(input tof_in_t b, input bit known, input tof_out_t want);
    int       gap;
    tof_out_t pred;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= b.command;
    in_if.channel  <= b.channel;
    in_if.stamp    <= b.stamp;
    in_if.read_bin <= b.read_bin;
    do @(posedge clk); while (!in_if.ready);
    pred = tof_bin(b);
    if (pred.status == ST_BINNED) begin
      hot_slots.push_back(pred.bin_index);
      if (hot_slots.size() > 16) void'(hot_slots.pop_front());
    end
    expected_q.push_back(known ? want : pred);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    script_row_t       script [$];
    tof_in_t           b;
    logic [63:0]       roll;
    logic [63:0]       reach;
    logic [63:0]       delta;
    logic [MASK_W-1:0] m;
    logic [SCALE_W-1:0] s;
    logic [CH_FIELD_W-1:0] ch;
    int                len;
    int                sent;
    int                n;
    int                pick;

    delta = '0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.command  <= CMD_PULSE;
    in_if.channel  <= '0;
    in_if.stamp    <= '0;
    in_if.read_bin <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_CHANNEL_MASK;
    cfg_wdata      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: only channel 0 enabled, one bin per tick
    script.push_back(known_row(CMD_READ, 0, 0, 0, ST_READ, 0, 0, 0));
    script.push_back(known_row(CMD_READ, 0, 0, 4095, ST_READ, 4095, 0, 0));
    script.push_back(known_row(CMD_EVENT, 0, 100, 0, ST_NO_PULSE, 0, 0, 0));
    script.push_back(known_row(CMD_PULSE, 1, 5, 0, ST_CH_OFF, 0, 0, 0));
    script.push_back(known_row(CMD_EVENT, 1, 5, 0, ST_CH_OFF, 0, 0, 0));
    script.push_back(known_row(CMD_PULSE, 0, 1000, 0, ST_PULSE, 0, 0, 0));
    script.push_back(known_row(CMD_EVENT, 0, 999, 0, ST_NEGATIVE, 0, 0, 0));
    script.push_back(known_row(CMD_EVENT, 0, 1000, 0, ST_BINNED, 0, 1, 1));
    script.push_back(known_row(CMD_EVENT, 0, 1000, 0, ST_BINNED, 0, 2, 2));
    script.push_back(known_row(CMD_EVENT, 0, 5095, 0, ST_BINNED, 4095, 1, 3));
    script.push_back(known_row(CMD_EVENT, 0, 5096, 0, ST_RANGE, 0, 0, 3));
    script.push_back(known_row(CMD_SPARE, 15, STAMP_TOP, 4095, ST_READ, 4095, 1, 3));
    script.push_back(known_row(CMD_PULSE, 0, 0, 0, ST_PULSE, 0, 0, 3));
    script.push_back(known_row(CMD_EVENT, 0, STAMP_TOP, 0, ST_RANGE, 0, 0, 3));
    script.push_back(known_row(CMD_EVENT, 0, 17, 0, ST_BINNED, 17, 1, 4));
    script.push_back(reg_row(REG_BIN_SCALE, 32'h0000_0000));
    script.push_back(known_row(CMD_EVENT, 0, 20, 0, ST_ZERO_SCALE, 0, 0, 4));
    script.push_back(known_row(CMD_EVENT, 2, 20, 0, ST_CH_OFF, 0, 0, 4));
    script.push_back(reg_row(REG_CHANNEL_MASK, 32'h0000_FFFF));
    script.push_back(known_row(CMD_EVENT, 15, 0, 0, ST_NO_PULSE, 0, 0, 4));
    script.push_back(known_row(CMD_PULSE, 15, STAMP_TOP, 0, ST_PULSE, 0, 0, 4));
    script.push_back(known_row(CMD_EVENT, 15, 0, 0, ST_ZERO_SCALE, 0, 0, 4));
    script.push_back(reg_row(REG_BIN_SCALE, 32'hFFFF_FFFF));
    script.push_back(reg_row(REG_SPARE_2, 32'h0000_0000));
    script.push_back(reg_row(REG_SPARE_3, 32'hFFFF_FFFF));
    script.push_back(beat_row(CMD_EVENT, 15, STAMP_TOP, 0));
    script.push_back(beat_row(CMD_PULSE, 7, 0, 0));
    script.push_back(beat_row(CMD_EVENT, 7, 16, 0));
    script.push_back(beat_row(CMD_EVENT, 7, 17, 0));
    script.push_back(reg_row(REG_BIN_SCALE, 32'h0000_0001));
    script.push_back(beat_row(CMD_EVENT, 7, STAMP_TOP, 0));
    script.push_back(beat_row(CMD_EVENT, 7, 48'h0000_0100_0000, 0));

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        set_reg(script[i].idx, script[i].data);
      end else begin
        push_beat(script[i].beat, script[i].known, script[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      len = 100;
      case (p)
        0: begin m = 16'hFFFF; s = 32'h0100_0000; end
        1: begin
          m = MASK_W'($urandom_range(0, 16'hFFFF));
          s = $urandom_range(32'h0010_0000, 32'h1000_0000);
        end
        2: begin m = 16'hFFFF; s = 32'hFFFF_FFFF; end
        3: begin m = 16'h0000; s = 32'h0000_0001; len = 30; end
        4: begin m = MASK_W'($urandom_range(0, 16'hFFFF)); s = 32'h0; len = 40; end
        5: begin m = 16'h8001; s = 32'h0000_0001; end
        6: begin m = MASK_W'($urandom_range(0, 16'hFFFF)) | 16'h0001; s = $urandom; end
        default: begin m = 16'hFFFF; s = 32'h0010_0000; end
      endcase
      settle();
      set_reg(REG_CHANNEL_MASK, CFG_DATA_W'(m));
      set_reg(REG_BIN_SCALE, CFG_DATA_W'(s));
      sent = 0;
      while (sent < len) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          roll = {$urandom, $urandom};
          b = '{command: CMD_W'($urandom_range(0, 3)), channel: CH_FIELD_W'($urandom),
                stamp: roll[STAMP_BITS-1:0], read_bin: RB_W'($urandom)};
          push_beat(b, 1'b0, '0);
          sent++;
        end else if (pick < 24) begin
          b.command  = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_READ;
          b.channel  = CH_FIELD_W'($urandom);
          b.stamp    = STAMP_BITS'({$urandom, $urandom});
          b.read_bin = (hot_slots.size() != 0 && $urandom_range(0, 2) != 0) ?
                       hot_slots[$urandom_range(0, hot_slots.size() - 1)] : RB_W'($urandom);
          push_beat(b, 1'b0, '0);
          sent++;
        end else begin
          ch = pick_channel();
          if (!pulse_seen[ch] || $urandom_range(0, 3) == 0) begin
            roll = {$urandom, $urandom};
            b = '{command: CMD_PULSE, channel: ch, stamp: roll[STAMP_BITS-1:0],
                  read_bin: RB_W'($urandom)};
            push_beat(b, 1'b0, '0);
            sent++;
          end
          reach = (scale_now == '0) ? 64'd8192 : ((64'(NUM_BINS) << Q_FRAC) / scale_now);
          n = $urandom_range(1, 6);
          repeat (n) begin
            // keep the last offset now and then so the same bin is hit back to back
            if ($urandom_range(0, 3) != 0) begin
              roll  = {$urandom, $urandom};
              delta = roll % (reach + reach / 8 + 1);
            end
            b.command  = CMD_EVENT;
            b.channel  = ch;
            b.read_bin = RB_W'($urandom);
            if ($urandom_range(0, 9) == 0)
              b.stamp = pulse_at[ch] - STAMP_BITS'($urandom_range(1, 64));
            else
              b.stamp = pulse_at[ch] + delta[STAMP_BITS-1:0];
            push_beat(b, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    int       gap;
    tof_out_t want;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("result beat with nothing outstanding: status %0d bin %0d count %0d",
                   out_if.status, out_if.bin_index, out_if.bin_count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.status !== want.status || out_if.bin_index !== want.bin_index ||
            out_if.bin_count !== want.bin_count ||
            out_if.total_events !== want.total_events) begin
          if (errors < 10)
            $display("result mismatch: exp st %0d bin %0d cnt %0d tot %0d, got st %0d bin %0d cnt %0d tot %0d",
                     want.status, want.bin_index, want.bin_count, want.total_events,
                     out_if.status, out_if.bin_index, out_if.bin_count, out_if.total_events);
          errors++;
        end
      end
    end
  end

endmodule
